@@ rtl/moesi_dir_pkg.sv @@
// ---------------------------------------------------------------------------
// moesi_dir_pkg
// Shared types and codes for the MOESI directory controller: request and
// result payloads, directory entry layout, action and line state codes.
// ---------------------------------------------------------------------------
package moesi_dir_pkg;

  // sizing
  localparam int DIR_ENTRIES = 1024;
  localparam int MAX_NODES   = 16;
  localparam int NODE_W      = 4;
  localparam int MASK_W      = 16;
  localparam int CNT_W       = 5;

  // action codes
  localparam logic [2:0] ACT_READ       = 3'd0;
  localparam logic [2:0] ACT_WRITE      = 3'd1;
  localparam logic [2:0] ACT_REM_INV    = 3'd2;
  localparam logic [2:0] ACT_REM_DOWN   = 3'd3;
  localparam logic [2:0] ACT_REM_WRBACK = 3'd4;

  // line state codes
  localparam logic [2:0] LS_I = 3'd0;
  localparam logic [2:0] LS_S = 3'd1;
  localparam logic [2:0] LS_E = 3'd2;
  localparam logic [2:0] LS_O = 3'd3;
  localparam logic [2:0] LS_M = 3'd4;

  // incoming request
  typedef struct packed {
    logic [2:0]        action;
    logic [9:0]        line_index;
    logic [NODE_W-1:0] requester_node;
  } dir_req_t;

  // result of one request
  typedef struct packed {
    logic [2:0]        result_state;
    logic [NODE_W-1:0] supply_node;
    logic              hit;
    logic [MASK_W-1:0] invalidate_mask;
    logic [CNT_W-1:0]  message_count;
    logic [CNT_W-1:0]  invalidation_count;
    logic              downgrade_done;
    logic              writeback_done;
    logic              remote_access;
    logic              entry_present;
    logic              dirty;
  } dir_res_t;

  // one directory entry as stored in memory
  typedef struct packed {
    logic              valid;
    logic [2:0]        state;
    logic              owner_valid;
    logic [NODE_W-1:0] owner;
    logic [MASK_W-1:0] sharers;
    logic              dirty;
  } dir_entry_t;

endpackage

@@ rtl/moesi_directory_controller_top.sv @@
// ---------------------------------------------------------------------------
// moesi_directory_controller_top
// MOESI directory over a range of cache lines. Entries live in one
// synchronous memory; each request reads its entry and walks the coherence
// state machine; reads, writes and remote actions that find it write it back.
// ---------------------------------------------------------------------------
//
//  channel   ports                     direction  handshake
//  request   start, busy, in_req       in         start & !busy
//  result    out_valid, out_res        out        one-cycle strobe
//  config    cfg_we, cfg_wdata         in         write on cfg_we
//
// A request reads its entry at accept, then does the update and write-back
// through the single memory port pair. The result strobes in the cycle
// after the update, while the next request may already be accepted.
// After reset a clearing pass zeroes every entry with busy high;
// configuration writes are taken throughout. The receiver cannot stall.
//
module moesi_directory_controller_top #(
  parameter int DIR_ENTRIES = moesi_dir_pkg::DIR_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  moesi_dir_pkg::dir_req_t       in_req,
  output logic                          out_valid,
  output moesi_dir_pkg::dir_res_t       out_res,
  input  logic                          cfg_we,
  input  logic [moesi_dir_pkg::NODE_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(DIR_ENTRIES);
  localparam int NW = moesi_dir_pkg::NODE_W;
  localparam int MW = moesi_dir_pkg::MASK_W;
  localparam int CW = moesi_dir_pkg::CNT_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } fsm_t;

  fsm_t                      state_r;
  logic [AW-1:0]             clr_cnt_r;
  logic [NW-1:0]             local_node_r;
  moesi_dir_pkg::dir_req_t   req_r;
  moesi_dir_pkg::dir_entry_t rd_data_r;
  logic                      out_valid_r;
  moesi_dir_pkg::dir_res_t   out_res_r;

  moesi_dir_pkg::dir_entry_t dir_mem [DIR_ENTRIES];

  logic                      accept;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  moesi_dir_pkg::dir_entry_t mem_wdata;

  // update results
  moesi_dir_pkg::dir_entry_t cur;
  moesi_dir_pkg::dir_entry_t upd;
  moesi_dir_pkg::dir_res_t   res;
  logic                      upd_we;
  logic [MW-1:0]             rb;
  logic [MW-1:0]             lb;
  logic [MW-1:0]             others;
  logic                      own_is_req;
  logic                      own_is_local;
  logic                      item_ok;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_node_r <= '0;
    end else if (cfg_we) begin
      local_node_r <= cfg_wdata;
    end
  end

  // memory write select: clearing pass or entry write-back
  always_comb begin
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else begin
      mem_we    = (state_r == S_EXEC) && upd_we;
      mem_waddr = AW'(req_r.line_index);
      mem_wdata = upd;
    end
  end

  // directory memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      dir_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_data_r <= dir_mem[AW'(in_req.line_index)];
    end
  end

  // coherence update for the request in flight
  always_comb begin
    cur          = rd_data_r.valid ? rd_data_r : '0;
    upd          = cur;
    upd.valid    = 1'b1;
    res          = '0;
    res.supply_node = local_node_r;
    upd_we       = 1'b0;
    rb           = MW'(1) << req_r.requester_node;
    lb           = MW'(1) << local_node_r;
    others       = cur.sharers & ~rb;
    own_is_req   = cur.owner_valid && (cur.owner == req_r.requester_node);
    own_is_local = cur.owner_valid && (cur.owner == local_node_r);
    item_ok      = (32'(req_r.line_index) < DIR_ENTRIES) &&
                   ({1'b0, req_r.requester_node} < (NW + 1)'(moesi_dir_pkg::MAX_NODES));

    if (item_ok) begin
      case (req_r.action)
        moesi_dir_pkg::ACT_READ: begin
          upd_we            = 1'b1;
          res.remote_access = (req_r.requester_node != local_node_r);
          res.dirty         = cur.dirty;
          if (own_is_req && (cur.state == moesi_dir_pkg::LS_E ||
                             cur.state == moesi_dir_pkg::LS_M ||
                             cur.state == moesi_dir_pkg::LS_O)) begin
            res.hit          = 1'b1;
            res.result_state = cur.state;
          end else if ((cur.sharers & rb) != '0) begin
            res.hit          = 1'b1;
            res.result_state = moesi_dir_pkg::LS_S;
          end else begin
            res.result_state = moesi_dir_pkg::LS_S;
            upd.sharers      = cur.sharers | rb;
            case (cur.state)
              moesi_dir_pkg::LS_I: begin
                upd.state       = moesi_dir_pkg::LS_S;
                upd.owner_valid = 1'b1;
                upd.owner       = req_r.requester_node;
              end
              moesi_dir_pkg::LS_E: begin
                // exclusive owner drops to sharer and supplies the data
                if (cur.owner_valid) begin
                  upd.sharers        = cur.sharers | rb | (MW'(1) << cur.owner);
                  upd.owner_valid    = 1'b0;
                  res.downgrade_done = 1'b1;
                  res.message_count  = CW'(1);
                  res.supply_node    = cur.owner;
                end
                upd.state = moesi_dir_pkg::LS_S;
              end
              moesi_dir_pkg::LS_M: begin
                if (cur.owner_valid) begin
                  res.message_count = CW'(1);
                  res.supply_node   = cur.owner;
                end
                upd.state = moesi_dir_pkg::LS_O;
              end
              moesi_dir_pkg::LS_O: begin
                if (cur.owner_valid) begin
                  res.message_count = CW'(1);
                  res.supply_node   = cur.owner;
                end
              end
              default: begin
              end
            endcase
          end
        end

        moesi_dir_pkg::ACT_WRITE: begin
          upd_we            = 1'b1;
          res.remote_access = (req_r.requester_node != local_node_r);
          if (own_is_req && (cur.state == moesi_dir_pkg::LS_E ||
                             cur.state == moesi_dir_pkg::LS_M)) begin
            res.hit = 1'b1;
          end else if (own_is_req && cur.state == moesi_dir_pkg::LS_O) begin
            // owner upgrades: invalidate the other sharers
            res.invalidate_mask    = others;
            res.invalidation_count = CW'($countones(others));
            res.message_count      = CW'($countones(others));
            upd.sharers            = '0;
          end else begin
            case (cur.state)
              moesi_dir_pkg::LS_S: begin
                res.invalidate_mask    = others;
                res.invalidation_count = CW'($countones(others));
                res.message_count      = CW'($countones(others));
              end
              moesi_dir_pkg::LS_E: begin
                if (cur.owner_valid) begin
                  res.invalidate_mask    = MW'(1) << cur.owner;
                  res.invalidation_count = CW'(1);
                  res.message_count      = CW'(1);
                end
              end
              moesi_dir_pkg::LS_M: begin
                if (cur.owner_valid) begin
                  res.supply_node    = cur.owner;
                  res.writeback_done = 1'b1;
                  res.message_count  = CW'(1);
                end
              end
              moesi_dir_pkg::LS_O: begin
                // owner supplies data, only sharers count as messages
                if (cur.owner_valid) begin
                  res.supply_node    = cur.owner;
                  res.writeback_done = 1'b1;
                end
                res.invalidate_mask    = others;
                res.invalidation_count = CW'($countones(others));
                res.message_count      = CW'($countones(others));
              end
              default: begin
              end
            endcase
            upd.owner_valid = 1'b1;
            upd.owner       = req_r.requester_node;
            upd.sharers     = '0;
          end
          upd.state        = moesi_dir_pkg::LS_M;
          upd.dirty        = 1'b1;
          res.result_state = moesi_dir_pkg::LS_M;
          res.dirty        = 1'b1;
        end

        moesi_dir_pkg::ACT_REM_INV: begin
          if (rd_data_r.valid) begin
            upd_we                 = 1'b1;
            res.entry_present      = 1'b1;
            res.invalidation_count = CW'(1);
            upd.sharers            = cur.sharers & ~lb;
            if (own_is_local) begin
              if (cur.state == moesi_dir_pkg::LS_M) begin
                upd.dirty          = 1'b1;
                res.writeback_done = 1'b1;
              end
              upd.owner_valid = 1'b0;
              upd.state       = moesi_dir_pkg::LS_I;
            end
            res.result_state = upd.state;
            res.dirty        = upd.dirty;
          end
        end

        moesi_dir_pkg::ACT_REM_DOWN: begin
          if (rd_data_r.valid) begin
            upd_we             = 1'b1;
            res.entry_present  = 1'b1;
            res.downgrade_done = 1'b1;
            if (own_is_local) begin
              if (cur.state == moesi_dir_pkg::LS_M) begin
                upd.state = moesi_dir_pkg::LS_O;
              end else if (cur.state == moesi_dir_pkg::LS_E) begin
                upd.state   = moesi_dir_pkg::LS_S;
                upd.sharers = cur.sharers | lb;
              end
            end
            res.result_state = upd.state;
            res.dirty        = upd.dirty;
          end
        end

        moesi_dir_pkg::ACT_REM_WRBACK: begin
          if (rd_data_r.valid) begin
            upd_we             = 1'b1;
            res.entry_present  = 1'b1;
            res.writeback_done = 1'b1;
            if (own_is_req) begin
              upd.dirty       = 1'b0;
              upd.owner_valid = 1'b0;
              upd.state       = moesi_dir_pkg::LS_I;
              upd.sharers     = cur.sharers & ~rb;
            end
            res.result_state = upd.state;
            res.dirty        = upd.dirty;
          end
        end

        default: begin
        end
      endcase
    end
  end

  // control state machine and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == AW'(DIR_ENTRIES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req_r   <= in_req;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          out_valid_r <= 1'b1;
          out_res_r   <= res;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ dv/moesi_directory_controller_top_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// moesi_directory_controller_top_test
// Self-checking test of the MOESI directory controller. Requests are sent
// through the start/busy handshake. The expected result of each accepted
// request is computed from a shadow copy of the directory and home node
// register. Every result strobe is checked field by field against the
// oldest expected result. A directed pass walks the coherence transitions.
// Random passes follow, under different home nodes and request gaps.
// ---------------------------------------------------------------------------
module moesi_directory_controller_top_test;

  localparam int          CYCLE_LIMIT      = 500000;
  localparam int          MAX_GAP          = 60;
  localparam int          ITEMS_PER_PASS   = 345;
  localparam logic [4:0]  NO_OWNER         = 5'd31;
  localparam logic [2:0]  ACT_FIRST_UNUSED = 3'd5;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  moesi_dir_pkg::dir_req_t        in_req;
  logic                           out_valid;
  moesi_dir_pkg::dir_res_t        out_res;
  logic                           cfg_we;
  logic [moesi_dir_pkg::NODE_W-1:0] cfg_wdata;

  // shadow directory and home node
  logic                             sh_valid   [moesi_dir_pkg::DIR_ENTRIES];
  logic [2:0]                       sh_state   [moesi_dir_pkg::DIR_ENTRIES];
  logic [4:0]                       sh_owner   [moesi_dir_pkg::DIR_ENTRIES];
  logic [moesi_dir_pkg::MASK_W-1:0] sh_sharers [moesi_dir_pkg::DIR_ENTRIES];
  logic                             sh_dirty   [moesi_dir_pkg::DIR_ENTRIES];
  logic [moesi_dir_pkg::NODE_W-1:0] sh_home;

  moesi_dir_pkg::dir_res_t outcome_q[$];
  int                      mismatch_count;
  int                      cycle_count;
  int                      hot_lines[6];

  moesi_directory_controller_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run time limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic logic [moesi_dir_pkg::MASK_W-1:0] node_mask(input logic [4:0] node);
    return (node < 5'd16) ? (16'd1 << node) : '0;
  endfunction

  function automatic moesi_dir_pkg::dir_req_t make_req(
    input logic [2:0]                       act,
    input logic [9:0]                       line,
    input logic [moesi_dir_pkg::NODE_W-1:0] node
  );
    moesi_dir_pkg::dir_req_t r;
    r.action         = act;
    r.line_index     = line;
    r.requester_node = node;
    return r;
  endfunction

  // invalidate all sharers but one node, then empty the sharer set
  function automatic void drop_sharers(input int ln, input logic [4:0] keep,
                                       inout moesi_dir_pkg::dir_res_t o);
    logic [moesi_dir_pkg::MASK_W-1:0] victims;
    victims = sh_sharers[ln] & ~node_mask(keep);
    for (int n = 0; n < moesi_dir_pkg::MASK_W; n++) begin
      if (victims[n]) begin
        o.invalidate_mask[n] = 1'b1;
        o.invalidation_count++;
        o.message_count++;
      end
    end
    sh_sharers[ln] = '0;
  endfunction

  // directory update and outcome of one accepted request
  function automatic moesi_dir_pkg::dir_res_t predict_outcome(
    input moesi_dir_pkg::dir_req_t r
  );
    moesi_dir_pkg::dir_res_t          o;
    int                               ln;
    logic [4:0]                       req;
    logic [4:0]                       home;
    logic [4:0]                       own;
    logic [2:0]                       st;
    logic [moesi_dir_pkg::MASK_W-1:0] rb;
    logic [moesi_dir_pkg::MASK_W-1:0] lb;
    o    = '0;
    o.supply_node = sh_home;
    ln   = int'(r.line_index);
    req  = {1'b0, r.requester_node};
    home = {1'b0, sh_home};
    rb   = node_mask(req);
    lb   = node_mask(home);
    if (r.action > moesi_dir_pkg::ACT_REM_WRBACK) return o;

    if (r.action == moesi_dir_pkg::ACT_READ || r.action == moesi_dir_pkg::ACT_WRITE) begin
      if (!sh_valid[ln]) begin
        sh_valid[ln]   = 1'b1;
        sh_state[ln]   = moesi_dir_pkg::LS_I;
        sh_owner[ln]   = NO_OWNER;
        sh_sharers[ln] = '0;
        sh_dirty[ln]   = 1'b0;
      end
      o.remote_access = (req != home);
    end else begin
      o.entry_present = sh_valid[ln];
    end
    st  = sh_state[ln];
    own = sh_owner[ln];

    if (r.action == moesi_dir_pkg::ACT_READ) begin
      if (own == req && (st == moesi_dir_pkg::LS_E || st == moesi_dir_pkg::LS_M ||
                         st == moesi_dir_pkg::LS_O)) begin
        o.hit = 1'b1;
        o.result_state = st;
      end else if ((sh_sharers[ln] & rb) != '0) begin
        o.hit = 1'b1;
        o.result_state = moesi_dir_pkg::LS_S;
      end else begin
        case (st)
          moesi_dir_pkg::LS_I: begin
            sh_state[ln] = moesi_dir_pkg::LS_S;
            sh_owner[ln] = req;
          end
          moesi_dir_pkg::LS_E: begin
            // exclusive owner drops to sharer and supplies the data
            if (own != NO_OWNER) begin
              sh_sharers[ln] = sh_sharers[ln] | node_mask(own);
              sh_owner[ln] = NO_OWNER;
              o.downgrade_done = 1'b1;
              o.message_count++;
              o.supply_node = own[3:0];
            end
            sh_state[ln] = moesi_dir_pkg::LS_S;
          end
          moesi_dir_pkg::LS_M: begin
            if (own != NO_OWNER) begin
              o.message_count++;
              o.supply_node = own[3:0];
            end
            sh_state[ln] = moesi_dir_pkg::LS_O;
          end
          moesi_dir_pkg::LS_O: begin
            if (own != NO_OWNER) begin
              o.message_count++;
              o.supply_node = own[3:0];
            end
          end
          default: ;
        endcase
        sh_sharers[ln] = sh_sharers[ln] | rb;
        o.result_state = moesi_dir_pkg::LS_S;
      end
      o.dirty = sh_dirty[ln];
    end else if (r.action == moesi_dir_pkg::ACT_WRITE) begin
      if (own == req && (st == moesi_dir_pkg::LS_E || st == moesi_dir_pkg::LS_M)) begin
        o.hit = 1'b1;
      end else if (own == req && st == moesi_dir_pkg::LS_O) begin
        drop_sharers(ln, req, o);
      end else begin
        case (st)
          moesi_dir_pkg::LS_S: drop_sharers(ln, req, o);
          moesi_dir_pkg::LS_E: begin
            if (own != NO_OWNER) begin
              o.invalidate_mask = o.invalidate_mask | node_mask(own);
              o.invalidation_count++;
              o.message_count++;
            end
          end
          moesi_dir_pkg::LS_M: begin
            if (own != NO_OWNER) begin
              o.supply_node = own[3:0];
              o.writeback_done = 1'b1;
              o.message_count++;
            end
          end
          moesi_dir_pkg::LS_O: begin
            // owner supplies data, only the sharers count as messages
            if (own != NO_OWNER) begin
              o.supply_node = own[3:0];
              o.writeback_done = 1'b1;
            end
            drop_sharers(ln, req, o);
          end
          default: ;
        endcase
        sh_owner[ln]   = req;
        sh_sharers[ln] = '0;
      end
      sh_state[ln]   = moesi_dir_pkg::LS_M;
      sh_dirty[ln]   = 1'b1;
      o.result_state = moesi_dir_pkg::LS_M;
      o.dirty        = 1'b1;
    end else if (o.entry_present) begin
      if (r.action == moesi_dir_pkg::ACT_REM_INV) begin
        sh_sharers[ln] = sh_sharers[ln] & ~lb;
        if (own == home) begin
          if (st == moesi_dir_pkg::LS_M) begin
            sh_dirty[ln] = 1'b1;
            o.writeback_done = 1'b1;
          end
          sh_owner[ln] = NO_OWNER;
          sh_state[ln] = moesi_dir_pkg::LS_I;
        end
        o.invalidation_count = 5'd1;
      end else if (r.action == moesi_dir_pkg::ACT_REM_DOWN) begin
        if (own == home) begin
          if (st == moesi_dir_pkg::LS_M) begin
            sh_state[ln] = moesi_dir_pkg::LS_O;
          end else if (st == moesi_dir_pkg::LS_E) begin
            sh_state[ln] = moesi_dir_pkg::LS_S;
            sh_sharers[ln] = sh_sharers[ln] | lb;
          end
        end
        o.downgrade_done = 1'b1;
      end else begin
        if (own == req) begin
          sh_dirty[ln]   = 1'b0;
          sh_owner[ln]   = NO_OWNER;
          sh_state[ln]   = moesi_dir_pkg::LS_I;
          sh_sharers[ln] = sh_sharers[ln] & ~rb;
        end
        o.writeback_done = 1'b1;
      end
      o.result_state = sh_state[ln];
      o.dirty        = sh_dirty[ln];
    end
    return o;
  endfunction

  // result checker
  always @(posedge clk) begin
    moesi_dir_pkg::dir_res_t want;
    if (rst_n && out_valid) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("result strobe with no request pending");
      end else begin
        want = outcome_q.pop_front();
        if (out_res.result_state !== want.result_state)
          report_mismatch($sformatf("result_state got %0d expected %0d",
                                    out_res.result_state, want.result_state));
        if (out_res.supply_node !== want.supply_node)
          report_mismatch($sformatf("supply_node got %0d expected %0d",
                                    out_res.supply_node, want.supply_node));
        if (out_res.hit !== want.hit)
          report_mismatch($sformatf("hit got %0b expected %0b",
                                    out_res.hit, want.hit));
        if (out_res.invalidate_mask !== want.invalidate_mask)
          report_mismatch($sformatf("invalidate_mask got %04h expected %04h",
                                    out_res.invalidate_mask, want.invalidate_mask));
        if (out_res.message_count !== want.message_count)
          report_mismatch($sformatf("message_count got %0d expected %0d",
                                    out_res.message_count, want.message_count));
        if (out_res.invalidation_count !== want.invalidation_count)
          report_mismatch($sformatf("invalidation_count got %0d expected %0d",
                                    out_res.invalidation_count,
                                    want.invalidation_count));
        if (out_res.downgrade_done !== want.downgrade_done)
          report_mismatch($sformatf("downgrade_done got %0b expected %0b",
                                    out_res.downgrade_done, want.downgrade_done));
        if (out_res.writeback_done !== want.writeback_done)
          report_mismatch($sformatf("writeback_done got %0b expected %0b",
                                    out_res.writeback_done, want.writeback_done));
        if (out_res.remote_access !== want.remote_access)
          report_mismatch($sformatf("remote_access got %0b expected %0b",
                                    out_res.remote_access, want.remote_access));
        if (out_res.entry_present !== want.entry_present)
          report_mismatch($sformatf("entry_present got %0b expected %0b",
                                    out_res.entry_present, want.entry_present));
        if (out_res.dirty !== want.dirty)
          report_mismatch($sformatf("dirty got %0b expected %0b",
                                    out_res.dirty, want.dirty));
      end
    end
  end

  // send one request, then idle the request side at random
  task automatic send_request(input moesi_dir_pkg::dir_req_t r, input int idle_pct);
    int gap;
    gap = 0;
    in_req <= r;
    start  <= 1'b1;
    do @(posedge clk); while (busy);
    outcome_q.push_back(predict_outcome(r));
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and let every pending result come back
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (outcome_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_home_node(input logic [moesi_dir_pkg::NODE_W-1:0] node);
    cfg_we    <= 1'b1;
    cfg_wdata <= node;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sh_home    = node;
  endtask

  // random request, mostly on a few hot lines so entries go deep
  function automatic moesi_dir_pkg::dir_req_t random_request();
    moesi_dir_pkg::dir_req_t r;
    int                      pick;
    int                      ln;
    pick = $urandom_range(99);
    if (pick < 38)      r.action = moesi_dir_pkg::ACT_READ;
    else if (pick < 63) r.action = moesi_dir_pkg::ACT_WRITE;
    else if (pick < 74) r.action = moesi_dir_pkg::ACT_REM_INV;
    else if (pick < 85) r.action = moesi_dir_pkg::ACT_REM_DOWN;
    else if (pick < 96) r.action = moesi_dir_pkg::ACT_REM_WRBACK;
    else                r.action = ACT_FIRST_UNUSED + 3'($urandom_range(2));
    if ($urandom_range(99) < 80) ln = hot_lines[$urandom_range(5)];
    else                         ln = int'($urandom_range(moesi_dir_pkg::DIR_ENTRIES - 1));
    r.line_index = 10'(ln);
    // writebacks from the real owner retire the line
    if (r.action == moesi_dir_pkg::ACT_REM_WRBACK && sh_valid[ln] &&
        sh_owner[ln] < 5'd16 && $urandom_range(1) == 1)
      r.requester_node = sh_owner[ln][3:0];
    else if ($urandom_range(99) < 25)
      r.requester_node = sh_home;
    else
      r.requester_node = 4'($urandom_range(15));
    return r;
  endfunction

  task automatic run_random(input int count, input int idle_pct,
                            input logic [moesi_dir_pkg::NODE_W-1:0] home);
    wait_idle();
    write_home_node(home);
    hot_lines[0] = 0;
    hot_lines[1] = moesi_dir_pkg::DIR_ENTRIES - 1;
    for (int i = 2; i < 6; i++)
      hot_lines[i] = int'($urandom_range(moesi_dir_pkg::DIR_ENTRIES - 1));
    for (int i = 0; i < count; i++) send_request(random_request(), idle_pct);
  endtask

  // coherence walk mostly on line 5 with the home node left at its reset value
  task automatic test_directed();
    send_request(make_req(moesi_dir_pkg::ACT_REM_INV, 10'd5, 4'd3), 0);  // no entry yet
    send_request(make_req(moesi_dir_pkg::ACT_READ, 10'd5, 4'd3), 0);  // miss from invalid
    send_request(make_req(moesi_dir_pkg::ACT_READ, 10'd5, 4'd3), 0);  // sharer hit
    send_request(make_req(moesi_dir_pkg::ACT_READ, 10'd5, 4'd7), 0);
    send_request(make_req(moesi_dir_pkg::ACT_WRITE, 10'd5, 4'd9), 0);  // invalidate sharers
    send_request(make_req(moesi_dir_pkg::ACT_WRITE, 10'd5, 4'd9), 0);  // owner write hit
    send_request(make_req(moesi_dir_pkg::ACT_READ, 10'd5, 4'd9), 0);  // owner read hit
    send_request(make_req(moesi_dir_pkg::ACT_READ, 10'd5, 4'd2), 0);  // modified to owned
    send_request(make_req(moesi_dir_pkg::ACT_READ, 10'd5, 4'd4), 0);  // forward from owner
    send_request(make_req(moesi_dir_pkg::ACT_WRITE, 10'd5, 4'd9), 0);  // owner upgrade
    send_request(make_req(moesi_dir_pkg::ACT_READ, 10'd5, 4'd1), 0);
    send_request(make_req(moesi_dir_pkg::ACT_WRITE, 10'd5, 4'd6), 0);  // write to foreign owned
    send_request(make_req(moesi_dir_pkg::ACT_WRITE, 10'd5, 4'd0), 0);  // home takes it over
    send_request(make_req(moesi_dir_pkg::ACT_REM_DOWN, 10'd5, 4'd8), 0);
    send_request(make_req(moesi_dir_pkg::ACT_REM_INV, 10'd5, 4'd8), 0);
    send_request(make_req(moesi_dir_pkg::ACT_READ, 10'd5, 4'd0), 0);
    send_request(make_req(moesi_dir_pkg::ACT_REM_WRBACK, 10'd5, 4'd0), 0);  // owner writeback
    send_request(make_req(moesi_dir_pkg::ACT_REM_WRBACK, 10'd5, 4'd11), 0); // non owner
    send_request(make_req(moesi_dir_pkg::ACT_WRITE, 10'd1023, 4'd15), 0);
    send_request(make_req(moesi_dir_pkg::ACT_WRITE, 10'd1023, 4'd0), 0);
    send_request(make_req(moesi_dir_pkg::ACT_REM_INV, 10'd1023, 4'd15), 0); // dirty home owner
    send_request(make_req(moesi_dir_pkg::ACT_REM_DOWN, 10'd0, 4'd0), 0);
    send_request(make_req(ACT_FIRST_UNUSED, 10'd1023, 4'd15), 0);
    send_request(make_req(ACT_FIRST_UNUSED + 3'd1, 10'd0, 4'd0), 0);
    send_request(make_req(ACT_FIRST_UNUSED + 3'd2, 10'd682, 4'd10), 0);
  endtask

  task automatic test_back_to_back();
    run_random(ITEMS_PER_PASS, 0, 4'd15);
  endtask

  task automatic test_sparse_requests();
    run_random(ITEMS_PER_PASS, 78, 4'($urandom_range(15)));
  endtask

  task automatic test_mixed_gaps();
    run_random(ITEMS_PER_PASS, 35, 4'($urandom_range(15)));
  endtask

  task automatic test_home_node_zero();
    run_random(ITEMS_PER_PASS, 0, 4'd0);
  endtask

  // stimulus and final verdict
  initial begin
    start     <= 1'b0;
    in_req    <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    mismatch_count = 0;
    sh_home = '0;
    for (int i = 0; i < moesi_dir_pkg::DIR_ENTRIES; i++) begin
      sh_valid[i]   = 1'b0;
      sh_state[i]   = moesi_dir_pkg::LS_I;
      sh_owner[i]   = NO_OWNER;
      sh_sharers[i] = '0;
      sh_dirty[i]   = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_back_to_back();
    test_sparse_requests();
    test_mixed_gaps();
    test_home_node_zero();
    wait_idle();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/moesi_dir_pkg.sv
rtl/moesi_directory_controller_top.sv
dv/moesi_directory_controller_top_test.sv
